@@ rtl/core/ptrs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the periodic task release scheduler.
// Used by ptrs_cell and periodic_task_release_scheduler_top; depends on nothing.

package ptrs_pkg;

    // Number of task slots, one cell per slot.
    localparam int MAX_TASKS = 8;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int TIME_W    = 32;
    localparam int SEL_W     = 3;
    localparam int OUT_IDX_W = 3;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_RUN    = 2'd1,
        CMD_CREATE = 2'd2,
        CMD_START  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_STOPPED = 2'd0,
        ST_READY   = 2'd1,
        ST_WAITING = 2'd2
    } task_state_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_WALK,
        FSM_FLUSH
    } fsm_state_t;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              tick_en;
        logic              run_start;
        logic              advance;
        logic [TIME_W-1:0] tick_now;
        logic [TIME_W-1:0] tick_next;
        logic [TIME_W-1:0] period;
    } cell_ctrl_t;

endpackage

@@ rtl/core/periodic_task_release_scheduler_top.sv @@
`timescale 1ns / 1ps
// Top level of the periodic task release scheduler: command decode, run-pass
// sequencer, tick counter, output register and the chain of ptrs_cell slots.
// Depends on ptrs_pkg and ptrs_cell.

// The scheduler keeps MAX_TASKS task slots in a row of cells, each holding a
// period, a next release time and a state, plus a 32-bit tick counter. Each
// input beat carries a command in s_axis_tuser. Tick, create and start beats
// finish in the cycle they are accepted, so the input is ready again on the
// next cycle. A run pass walks a token down the cell chain one slot per
// cycle when not paused; each ready slot it meets has its release time
// advanced by its period and is reported as one output beat, with tlast on
// the last report of the pass. A run pass holds the input while it walks
// every slot and flushes its held report, and longer while the output side
// stalls: the walk pauses while a report waits for room in the output register.
// A pass that finds no ready slot produces no output beats. Create is
// ignored when all slots are in use, start of a slot not yet created is
// ignored, and the tick compare is a plain unsigned compare with no wrap.

module periodic_task_release_scheduler_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] task_select, [34:3] period, [39:35] zero
    input  logic [39:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] dispatched_task, [7:3] zero
    output logic [7:0]  m_axis_tdata,
    // last_of_pass
    output logic        m_axis_tlast
);

    localparam int N = ptrs_pkg::MAX_TASKS;

    ptrs_pkg::fsm_state_t             fsm_reg, fsm_next;
    logic [ptrs_pkg::TIME_W-1:0]      tick_reg, tick_next;
    logic [ptrs_pkg::CNT_W-1:0]       created_reg, created_next;
    logic [ptrs_pkg::IDX_W-1:0]       pos_reg, pos_next;
    logic [ptrs_pkg::IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                             pend_valid_reg, pend_valid_next;

    logic                             out_valid_reg, out_valid_next;
    logic [ptrs_pkg::OUT_IDX_W-1:0]   out_task_reg, out_task_next;
    logic                             out_last_reg, out_last_next;

    ptrs_pkg::cell_ctrl_t             ctl;
    ptrs_pkg::cmd_t                   cmd;
    logic [ptrs_pkg::SEL_W-1:0]       task_select;
    logic [ptrs_pkg::TIME_W-1:0]      period;
    logic                             in_fire;
    logic                             out_free;
    logic                             do_create;
    logic                             do_start;
    logic                             hit_any;

    logic [N-1:0]                     sel_create;
    logic [N-1:0]                     sel_start;
    logic [N-1:0]                     token_chain;
    logic [N-1:0]                     hit_vec;

    assign cmd         = ptrs_pkg::cmd_t'(s_axis_tuser);
    assign task_select = s_axis_tdata[ptrs_pkg::SEL_W-1:0];
    assign period      = s_axis_tdata[ptrs_pkg::SEL_W +: ptrs_pkg::TIME_W];

    assign s_axis_tready = (fsm_reg == ptrs_pkg::FSM_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 8'(out_task_reg);
    assign m_axis_tlast  = out_last_reg;

    // The output register can take a new report when empty or being drained.
    assign out_free = !out_valid_reg || m_axis_tready;

    assign tick_next = tick_reg + 1'b1;

    // Create fills the next free slot; start needs a slot already created.
    assign do_create = in_fire && (cmd == ptrs_pkg::CMD_CREATE) &&
                       (32'(created_reg) < 32'(N));
    assign do_start  = in_fire && (cmd == ptrs_pkg::CMD_START) &&
                       (32'(task_select) < 32'(created_reg));

    // Only one cell holds the token, so at most one hit is raised.
    always_comb
    begin
        hit_any = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            hit_any = hit_any | hit_vec[i];
        end
    end

    always_comb
    begin
        fsm_next        = fsm_reg;
        created_next    = created_reg;
        pos_next        = pos_reg;
        pend_idx_next   = pend_idx_reg;
        pend_valid_next = pend_valid_reg;
        out_task_next   = out_task_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;

        ctl.tick_en   = 1'b0;
        ctl.run_start = 1'b0;
        ctl.advance   = 1'b0;
        ctl.tick_now  = tick_reg;
        ctl.tick_next = tick_next;
        ctl.period    = period;

        if (do_create)
        begin
            created_next = created_reg + 1'b1;
        end

        unique case (fsm_reg)
            ptrs_pkg::FSM_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (cmd)
                        ptrs_pkg::CMD_TICK:
                        begin
                            ctl.tick_en = 1'b1;
                        end
                        ptrs_pkg::CMD_RUN:
                        begin
                            ctl.run_start   = 1'b1;
                            pos_next        = '0;
                            pend_valid_next = 1'b0;
                            fsm_next        = ptrs_pkg::FSM_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ptrs_pkg::FSM_WALK:
            begin
                // A new hit pushes the previous one out, which needs room.
                if (!(hit_any && pend_valid_reg && !out_free))
                begin
                    ctl.advance = 1'b1;
                    if (hit_any)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_task_next  = ptrs_pkg::OUT_IDX_W'(pend_idx_reg);
                            out_last_next  = 1'b0;
                        end
                        pend_idx_next   = pos_reg;
                        pend_valid_next = 1'b1;
                    end
                    if (pos_reg == ptrs_pkg::IDX_W'(N - 1))
                    begin
                        fsm_next = ptrs_pkg::FSM_FLUSH;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end

            ptrs_pkg::FSM_FLUSH:
            begin
                // The held report is the last of the pass.
                if (!pend_valid_reg)
                begin
                    fsm_next = ptrs_pkg::FSM_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_task_next   = ptrs_pkg::OUT_IDX_W'(pend_idx_reg);
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    fsm_next        = ptrs_pkg::FSM_IDLE;
                end
            end

            default:
            begin
                fsm_next = ptrs_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= ptrs_pkg::FSM_IDLE;
            tick_reg       <= '0;
            created_reg    <= '0;
            pos_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fsm_reg        <= fsm_next;
            created_reg    <= created_next;
            pos_reg        <= pos_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (ctl.tick_en)
            begin
                tick_reg <= tick_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        out_task_reg <= out_task_next;
        out_last_reg <= out_last_next;
    end

    // The chain of slot cells. The token enters at slot zero on a run start.
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic token_in;

            assign sel_create[gi] = do_create && (32'(created_reg) == gi);
            assign sel_start[gi]  = do_start && (32'(task_select) == gi);

            if (gi == 0)
            begin : g_head
                assign token_in = ctl.run_start;
            end
            else
            begin : g_link
                assign token_in = token_chain[gi-1];
            end

            ptrs_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .sel_create (sel_create[gi]),
                .sel_start  (sel_start[gi]),
                .token_in   (token_in),
                .token_out  (token_chain[gi]),
                .hit        (hit_vec[gi])
            );
        end
    endgenerate

endmodule

@@ rtl/core/ptrs_cell.sv @@
`timescale 1ns / 1ps
// One task slot of the scheduler chain: period, next release time and state.
// Depends on ptrs_pkg for the broadcast control struct and the state type.

module ptrs_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ptrs_pkg::cell_ctrl_t ctl,
    input  logic                sel_create,
    input  logic                sel_start,
    input  logic                token_in,
    output logic                token_out,
    output logic                hit
);

    ptrs_pkg::task_state_t               state_reg, state_next;
    logic                                token_reg, token_next;
    logic [ptrs_pkg::TIME_W-1:0]         period_reg, period_next;
    logic [ptrs_pkg::TIME_W-1:0]         release_reg, release_next;

    assign token_out = token_reg;
    assign hit       = token_reg && (state_reg == ptrs_pkg::ST_READY);

    always_comb
    begin
        state_next   = state_reg;
        period_next  = period_reg;
        release_next = release_reg;
        token_next   = token_reg;

        // The run token moves one cell per step of the pass.
        if (ctl.run_start || ctl.advance)
        begin
            token_next = token_in;
        end

        if (sel_create)
        begin
            period_next = ctl.period;
            state_next  = ptrs_pkg::ST_STOPPED;
        end
        else if (sel_start)
        begin
            release_next = ctl.tick_now;
            state_next   = ptrs_pkg::ST_READY;
        end
        else if (ctl.tick_en && (state_reg == ptrs_pkg::ST_WAITING) &&
                 (release_reg <= ctl.tick_next))
        begin
            state_next = ptrs_pkg::ST_READY;
        end
        else if (ctl.advance && hit)
        begin
            release_next = release_reg + period_reg;
            state_next   = ptrs_pkg::ST_WAITING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptrs_pkg::ST_STOPPED;
            token_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            token_reg <= token_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg  <= period_next;
        release_reg <= release_next;
    end

endmodule

@@ sim/periodic_task_release_scheduler_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for periodic_task_release_scheduler_top: drives command beats,
// predicts dispatch beats with its own scheduler model, and compares them at the output.
// Depends on ptrs_pkg and the periodic_task_release_scheduler_top RTL.

module periodic_task_release_scheduler_top_test;

    import ptrs_pkg::*;

    // One predicted output beat: slot index plus the end-of-pass flag.
    typedef struct packed {
        logic [OUT_IDX_W-1:0] slot;
        logic                 last;
    } dispatch_t;

    // Scoreboard with its own copy of the scheduler state. Every accepted command
    // beat is applied to that state; run passes push the dispatches they cause.
    class dispatch_scoreboard;
        logic [TIME_W-1:0] tick_now;
        int unsigned       n_created;
        logic [TIME_W-1:0] slot_period [MAX_TASKS];
        logic [TIME_W-1:0] slot_release[MAX_TASKS];
        task_state_t       slot_state  [MAX_TASKS];
        dispatch_t         due_q[$];

        int errors;
        int n_beats;
        int n_runs_empty;
        int n_checked;
        int n_create_full;
        int n_start_bad;
        int n_released;

        function new();
            tick_now  = '0;
            n_created = 0;
            for (int s = 0; s < MAX_TASKS; s++)
            begin
                slot_period[s]  = '0;
                slot_release[s] = '0;
                slot_state[s]   = ST_STOPPED;
            end
            errors        = 0;
            n_beats       = 0;
            n_runs_empty  = 0;
            n_checked     = 0;
            n_create_full = 0;
            n_start_bad   = 0;
            n_released    = 0;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // Apply one accepted command beat to the predicted state.
        function void note_command(cmd_t cmd, logic [SEL_W-1:0] sel, logic [TIME_W-1:0] period);
            int n;
            dispatch_t d;
            n_beats++;
            case (cmd)
                CMD_TICK:
                begin
                    tick_now = tick_now + 1'b1;
                    for (int s = 0; s < n_created; s++)
                    begin
                        if (slot_state[s] == ST_WAITING && tick_now >= slot_release[s])
                        begin
                            slot_state[s] = ST_READY;
                            n_released++;
                        end
                    end
                end
                CMD_RUN:
                begin
                    n = 0;
                    for (int s = 0; s < n_created; s++)
                    begin
                        if (slot_state[s] == ST_READY)
                        begin
                            slot_release[s] = slot_release[s] + slot_period[s];
                            slot_state[s]   = ST_WAITING;
                            d.slot = s[OUT_IDX_W-1:0];
                            d.last = 1'b0;
                            due_q.push_back(d);
                            n++;
                        end
                    end
                    if (n > 0)
                        due_q[due_q.size() - 1].last = 1'b1;
                    else
                        n_runs_empty++;
                end
                CMD_CREATE:
                begin
                    if (n_created < MAX_TASKS)
                    begin
                        slot_period[n_created] = period;
                        slot_state[n_created]  = ST_STOPPED;
                        n_created++;
                    end
                    else
                        n_create_full++;
                end
                default:
                begin
                    if (sel < n_created)
                    begin
                        slot_release[sel] = tick_now;
                        slot_state[sel]   = ST_READY;
                    end
                    else
                        n_start_bad++;
                end
            endcase
        endfunction

        // Compare one accepted output beat against the oldest predicted dispatch.
        function void check_dispatch(logic [OUT_IDX_W-1:0] slot, logic last);
            dispatch_t d;
            if (due_q.size() == 0)
            begin
                $error("unexpected dispatch beat: dispatched_task=%0d last_of_pass=%0d",
                       slot, last);
                errors++;
                return;
            end
            d = due_q.pop_front();
            n_checked++;
            if (slot !== d.slot)
            begin
                $error("dispatched_task mismatch: expected %0d, actual %0d", d.slot, slot);
                errors++;
            end
            if (last !== d.last)
            begin
                $error("last_of_pass mismatch: expected %0d, actual %0d", d.last, last);
                errors++;
            end
        endfunction
    endclass

    // Countdown loaded when the receiver starts one long stall.
    localparam int LONG_HOLD = 260;
    // Cycles allowed for outstanding dispatches to arrive once the sender pauses.
    localparam int DRAIN_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [2:0] task_select, [34:3] period, [39:35] zero
    logic [39:0] s_axis_tdata = '0;
    // [1:0] cmd
    logic [1:0]  s_axis_tuser = '0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [2:0] dispatched_task, [7:3] zero
    logic [7:0]  m_axis_tdata;
    // last_of_pass
    logic        m_axis_tlast;

    dispatch_scoreboard sb = new();

    // Idle rates in percent; the sender's is read only by the stimulus process.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    // Each increment asks the receiver process for one long hold-off.
    int hold_requests = 0;

    periodic_task_release_scheduler_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: random back-pressure at the current idle rate. When a hold-off is
    // requested, tready stays low while a count loaded with LONG_HOLD runs down,
    // so the output register and then the run-pass walk stall as beats keep coming.
    int hold_left = 0;
    int hold_seen = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Output monitor: every accepted dispatch beat goes to the scoreboard. Outputs
    // are sampled at the edge, before the block's own updates take effect.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_dispatch(m_axis_tdata[OUT_IDX_W-1:0], m_axis_tlast);
    end

    // Offer one command beat, with random idle cycles ahead of it, and return at
    // the edge where it is accepted. The scoreboard learns of it at that edge.
    task automatic send_cmd(cmd_t cmd, logic [SEL_W-1:0] sel, logic [TIME_W-1:0] period);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'd0, period, sel};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_command(cmd, sel, period);
    endtask

    // Random command beat. Most beats are ticks, run passes and starts of created
    // slots so that tasks keep cycling through ready and waiting; the rest are
    // creates (ignored once all slots are full) and starts of arbitrary slots.
    task automatic send_random_cmd();
        int r;
        logic [SEL_W-1:0]  sel;
        logic [TIME_W-1:0] period;
        r      = $urandom_range(99);
        sel    = SEL_W'($urandom_range(MAX_TASKS - 1));
        period = ($urandom_range(9) < 8) ? $urandom_range(6) : $urandom;
        if (r < 38)
            send_cmd(CMD_TICK, sel, period);
        else if (r < 68)
            send_cmd(CMD_RUN, sel, period);
        else if (r < 90)
        begin
            if (sb.n_created > 0 && $urandom_range(9) < 8)
                sel = SEL_W'($urandom_range(sb.n_created - 1));
            send_cmd(CMD_START, sel, period);
        end
        else
            send_cmd(CMD_CREATE, sel, period);
    endtask

    // Sender pause: hold off until every predicted dispatch has arrived or the drain
    // limit runs out, then idle past the end of any run pass so the block is at rest.
    task automatic wait_all_dispatched();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (MAX_TASKS + 4) @(posedge clk);
    endtask

    // Random phase at the given idle rates, optionally opening with a long receiver
    // hold-off while the sender keeps starting all created slots and running passes.
    task automatic random_phase(int tx_pct, int rx_pct, int n_beats, bit with_hold);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        if (with_hold)
        begin
            hold_requests <= hold_requests + 1;
            for (int k = 0; k < 4; k++)
            begin
                for (int s = 0; s < sb.n_created; s++)
                    send_cmd(CMD_START, s[SEL_W-1:0], '0);
                send_cmd(CMD_RUN, '0, '0);
            end
        end
        repeat (n_beats)
            send_random_cmd();
        wait_all_dispatched();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the first phase's idle rates on both sides.
        tx_idle_pct = 22;
        rx_idle_pct <= 46;
        send_cmd(CMD_START,  3'd7, '0);               // start of a slot not yet created
        send_cmd(CMD_RUN,    3'd0, '0);               // pass with nothing ready
        send_cmd(CMD_TICK,   3'd0, '0);
        send_cmd(CMD_CREATE, 3'd0, 32'h0000_0000);    // zero period: always due again
        send_cmd(CMD_CREATE, 3'd0, 32'hFFFF_FFFF);    // release time wraps below the count
        send_cmd(CMD_CREATE, 3'd0, 32'h0000_0001);
        send_cmd(CMD_CREATE, 3'd0, 32'h8000_0000);
        send_cmd(CMD_CREATE, 3'd0, 32'h0000_0003);
        send_cmd(CMD_START,  3'd6, '0);               // still beyond the created slots
        send_cmd(CMD_RUN,    3'd0, '0);               // created but stopped: no dispatch
        for (int s = 0; s < 5; s++)
            send_cmd(CMD_START, s[SEL_W-1:0], '0);
        send_cmd(CMD_RUN,    3'd0, '0);               // five dispatches in slot order
        send_cmd(CMD_TICK,   3'd0, '0);
        send_cmd(CMD_RUN,    3'd0, '0);
        send_cmd(CMD_START,  3'd5, '0);
        send_cmd(CMD_TICK,   3'd0, '0);
        send_cmd(CMD_TICK,   3'd0, '0);
        send_cmd(CMD_RUN,    3'd0, '0);
        send_cmd(CMD_START,  3'd3, '0);               // restart of a waiting slot
        send_cmd(CMD_RUN,    3'd0, '0);
        wait_all_dispatched();

        // The remaining slots get filled by random creates early in the first phase.
        random_phase(22, 46, 120, 1'b1);
        send_cmd(CMD_CREATE, 3'd0, 32'hFFFF_FFFF);    // all slots taken by now
        random_phase(46, 22, 110, 1'b0);
        random_phase(0,  0,  95, 1'b1);

        if (sb.pending() > 0)
        begin
            $error("%0d predicted dispatch beats never arrived", sb.pending());
            sb.errors++;
        end

        $display("Covered %0d command beats with %0d dispatches checked and %0d tick releases.",
                 sb.n_beats, sb.n_checked, sb.n_released);
        $display("Ignored commands: %0d creates when full, %0d starts of uncreated slots;",
                 sb.n_create_full, sb.n_start_bad);
        $display("Run passes with nothing ready: %0d.", sb.n_runs_empty);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run including the long hold-offs.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
